// ===== hdl/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_XORI  = 6'h0E;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_LH    = 6'h21;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_LBU   = 6'h24;
	localparam logic [5:0] OP_LHU   = 6'h25;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SH    = 6'h29;
	localparam logic [5:0] OP_SW    = 6'h2B;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	localparam logic [31:0] HALT_CODE_RST = 32'd10;
	localparam logic [2:0]  COST_JUMP = 3'd3;
	localparam logic [2:0]  COST_ALU  = 3'd4;
	localparam logic [2:0]  COST_MEM  = 3'd5;
	localparam logic [2:0]  COST_NONE = 3'd0;

	// decoded operation class carried through the queue
	typedef enum logic [4:0] {
		K_SLL, K_SRL, K_SRA, K_SLLV, K_SRLV, K_SRAV, K_JR, K_JALR,
		K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_NOR, K_SLT, K_SLTU,
		K_J, K_JAL, K_BEQ, K_BNE, K_ADDI, K_SLTI, K_SLTIU, K_ANDI,
		K_ORI, K_XORI, K_LUI, K_MEM, K_UNK_FN, K_UNK_OP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        halt_cand;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [4:0]  sh;
		logic [15:0] imm;
		logic [25:0] target;
	} dec_t;

	localparam int QDEPTH = 2;

endpackage

// ===== hdl/mie_front.sv =====
`timescale 1ns / 1ps
module mie_front
	import mie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instruction_word,
	output logic        q_valid,
	output dec_t        q_head,
	input  logic        q_pop
);

	dec_t       dec;
	dec_t       mem_q [QDEPTH];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic [5:0] op, fn;
	logic       do_push;

	assign op = instruction_word[31:26];
	assign fn = instruction_word[5:0];

	// classify the instruction
	always_comb begin
		dec.halt_cand = (instruction_word[31:4] == 28'd0);
		dec.rs = instruction_word[25:21];
		dec.rt = instruction_word[20:16];
		dec.rd = instruction_word[15:11];
		dec.sh = instruction_word[10:6];
		dec.imm = instruction_word[15:0];
		dec.target = instruction_word[25:0];
		dec.kind = K_UNK_OP;
		case (op)
			OP_RTYPE: begin
				case (fn)
					FN_SLL: dec.kind = K_SLL;
					FN_SRL: dec.kind = K_SRL;
					FN_SRA: dec.kind = K_SRA;
					FN_SLLV: dec.kind = K_SLLV;
					FN_SRLV: dec.kind = K_SRLV;
					FN_SRAV: dec.kind = K_SRAV;
					FN_JR: dec.kind = K_JR;
					FN_JALR: dec.kind = K_JALR;
					FN_ADD, FN_ADDU: dec.kind = K_ADD;
					FN_SUB, FN_SUBU: dec.kind = K_SUB;
					FN_AND: dec.kind = K_AND;
					FN_OR: dec.kind = K_OR;
					FN_XOR: dec.kind = K_XOR;
					FN_NOR: dec.kind = K_NOR;
					FN_SLT: dec.kind = K_SLT;
					FN_SLTU: dec.kind = K_SLTU;
					default: dec.kind = K_UNK_FN;
				endcase
			end
			OP_J: dec.kind = K_J;
			OP_JAL: dec.kind = K_JAL;
			OP_BEQ: dec.kind = K_BEQ;
			OP_BNE: dec.kind = K_BNE;
			OP_ADDI, OP_ADDIU: dec.kind = K_ADDI;
			OP_SLTI: dec.kind = K_SLTI;
			OP_SLTIU: dec.kind = K_SLTIU;
			OP_ANDI: dec.kind = K_ANDI;
			OP_ORI: dec.kind = K_ORI;
			OP_XORI: dec.kind = K_XORI;
			OP_LUI: dec.kind = K_LUI;
			OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW:
				dec.kind = K_MEM;
			default: dec.kind = K_UNK_OP;
		endcase
	end

	assign full    = (cnt_q == 2'(QDEPTH));
	assign do_push = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = mem_q[rptr_q];

	// store decoded items
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= dec;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(q_pop);
		end
	end

endmodule

// ===== hdl/mie_back.sv =====
`timescale 1ns / 1ps
module mie_back
	import mie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        q_valid,
	input  dec_t        q_head,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic        dest_write,
	output logic        halted,
	output logic [2:0]  cycle_cost,
	output logic        memory_op,
	output logic        unknown_op
);

	logic [31:0] rf_q [32];
	logic [31:0] rf_vld_q;
	logic [31:0] pc_q, halt_code_q;
	logic        halt_q;
	logic        out_vld_q;
	logic [31:0] a, b, r2, pc4, simm, zimm, nxt, wval;
	logic [4:0]  wreg;
	logic        wr, mem, unk, hit, stop;
	logic [2:0]  cost;

	assign a  = rf_vld_q[q_head.rs] ? rf_q[q_head.rs] : 32'd0;
	assign b  = rf_vld_q[q_head.rt] ? rf_q[q_head.rt] : 32'd0;
	assign r2 = rf_vld_q[2] ? rf_q[2] : 32'd0;
	assign pc4 = pc_q + 32'd4;
	assign simm = {{16{q_head.imm[15]}}, q_head.imm};
	assign zimm = {16'd0, q_head.imm};

	// result register frees on transfer, so execute while it drains
	assign empty = !out_vld_q;
	assign q_pop = q_valid && (!out_vld_q || pop);
	assign hit   = halt_q || (q_head.halt_cand && r2 == halt_code_q);

	// execute
	always_comb begin
		nxt = pc4; wval = 32'd0; wreg = q_head.rt; wr = 1'b1;
		mem = 1'b0; unk = 1'b0; cost = COST_ALU;
		case (q_head.kind)
			K_SLL: begin wreg = q_head.rd; wval = b << q_head.sh; end
			K_SRL: begin wreg = q_head.rd; wval = b >> q_head.sh; end
			K_SRA: begin wreg = q_head.rd; wval = $unsigned($signed(b) >>> q_head.sh); end
			K_SLLV: begin wreg = q_head.rd; wval = b << a[4:0]; end
			K_SRLV: begin wreg = q_head.rd; wval = b >> a[4:0]; end
			K_SRAV: begin wreg = q_head.rd; wval = $unsigned($signed(b) >>> a[4:0]); end
			K_JR: begin nxt = a; wr = 1'b0; cost = COST_JUMP; end
			K_JALR: begin wreg = q_head.rd; nxt = a; wval = pc4; cost = COST_JUMP; end
			K_ADD: begin wreg = q_head.rd; wval = a + b; end
			K_SUB: begin wreg = q_head.rd; wval = a - b; end
			K_AND: begin wreg = q_head.rd; wval = a & b; end
			K_OR: begin wreg = q_head.rd; wval = a | b; end
			K_XOR: begin wreg = q_head.rd; wval = a ^ b; end
			K_NOR: begin wreg = q_head.rd; wval = ~(a | b); end
			K_SLT: begin wreg = q_head.rd; wval = {31'd0, $signed(a) < $signed(b)}; end
			K_SLTU: begin wreg = q_head.rd; wval = {31'd0, a < b}; end
			K_J, K_JAL: begin
				nxt = {pc4[31:28], q_head.target, 2'b00};
				cost = COST_JUMP;
				wr = (q_head.kind == K_JAL);
				wreg = 5'd31; wval = pc4;
			end
			K_BEQ, K_BNE: begin
				wr = 1'b0; cost = COST_JUMP;
				if ((a == b) == (q_head.kind == K_BEQ)) nxt = pc4 + {simm[29:0], 2'b00};
			end
			K_ADDI: wval = a + simm;
			K_SLTI: wval = {31'd0, $signed(a) < $signed(simm)};
			K_SLTIU: wval = {31'd0, a < simm};
			K_ANDI: wval = a & zimm;
			K_ORI: wval = a | zimm;
			K_XORI: wval = a ^ zimm;
			K_LUI: wval = {q_head.imm, 16'd0};
			K_MEM: begin wr = 1'b0; mem = 1'b1; cost = COST_MEM; end
			K_UNK_FN: begin wreg = q_head.rd; wr = 1'b0; unk = 1'b1; end
			default: begin wr = 1'b0; unk = 1'b1; cost = COST_NONE; end
		endcase
		if (wreg == 5'd0) wr = 1'b0;
		if (!wr) begin wreg = 5'd0; wval = 32'd0; end
	end

	assign stop = q_pop && hit;

	// register file contents
	always_ff @(posedge clk) begin
		if (q_pop && !hit && wr) rf_q[wreg] <= wval;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			next_pc    <= hit ? pc_q : nxt;
			dest_reg   <= hit ? 5'd0 : wreg;
			dest_value <= hit ? 32'd0 : wval;
			dest_write <= !hit && wr;
			halted     <= hit;
			cycle_cost <= hit ? COST_NONE : cost;
			memory_op  <= !hit && mem;
			unknown_op <= !hit && unk;
		end
	end

	// architectural control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q    <= '0;
			pc_q        <= 32'd0;
			halt_q      <= 1'b0;
			halt_code_q <= HALT_CODE_RST;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) halt_code_q <= cfg_wdata;
			if (stop) halt_q <= 1'b1;
			if (q_pop && !hit) begin
				pc_q <= nxt;
				if (wr) rf_vld_q[wreg] <= 1'b1;
			end
			if (q_pop) out_vld_q <= 1'b1;
			else if (pop) out_vld_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/mips32_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// channel  handshake        payload
// input    push / full      instruction_word
// result   empty / pop      next_pc dest_reg dest_value dest_write halted
//                           cycle_cost memory_op unknown_op
// config   cfg_we           cfg_wdata (halt_code)
// One instruction per cycle sustained while the result port is popped; an
// instruction is written into the decode queue when it transfers in, and is
// then executed from the queue head into the result register.
// The execute loop (register file read, ALU, write back) sets the rate.
// Reset clears the PC, halt flag, register valid bits and queue at once.
// A stalled result port backs up the two-entry decode queue, then full rises.
module mips32_integer_execute_unit
	import mie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instruction_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic        dest_write,
	output logic        halted,
	output logic [2:0]  cycle_cost,
	output logic        memory_op,
	output logic        unknown_op,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic q_valid, q_pop;
	dec_t q_head;

	mie_front u_front (
		.clk, .arst_n, .push, .full, .instruction_word,
		.q_valid, .q_head, .q_pop
	);

	mie_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .q_valid, .q_head, .q_pop,
		.empty, .pop, .next_pc, .dest_reg, .dest_value, .dest_write,
		.halted, .cycle_cost, .memory_op, .unknown_op
	);

	a_no_write_on_halt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && halted |-> !dest_write && cycle_cost == COST_NONE)
		else $error("halt result carries a write");
	a_r0_never: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && dest_write |-> dest_reg != 5'd0)
		else $error("write to r0 reported");
	a_pop_needs_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("execute took from an empty queue");
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && halted && pop ##1 !empty |-> halted)
		else $error("halt flag dropped");

endmodule
